[rtl/lph_pkg.sv]
// Package for the linear-probe hash table: sizes, codes, item and slot types.
// No dependencies; used by lph_mod, linear_probe_hash_table and the testbench.
`default_nettype none
package lph_pkg;

    localparam int MAX_SLOTS = 1024;
    localparam int MIN_SLOTS = 32;
    localparam int ADDR_W    = $clog2(MAX_SLOTS);
    localparam int SIZE_W    = ADDR_W + 1;
    localparam int WORD_W    = 32;
    localparam int PCT_W     = 7;
    localparam int PROD_W    = 19;
    localparam int PCT_SCALE = 100;
    localparam int RESET_FILL = 75;

    typedef enum logic [1:0] {
        ACT_INSERT   = 2'd0,
        ACT_REMOVE   = 2'd1,
        ACT_RETRIEVE = 2'd2,
        ACT_GET      = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_SAT      = 2'd3
    } t_status;

    typedef enum logic {
        CFG_INIT_SIZE = 1'b0,
        CFG_FILL_PCT  = 1'b1
    } t_cfg_index;

    typedef enum logic [2:0] {
        M_INSERT,
        M_REMOVE,
        M_RETRIEVE,
        M_GET,
        M_PLACE
    } t_mode;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CALC,
        S_DECIDE,
        S_RS_RD,
        S_RS_CHK,
        S_RS_WAIT,
        S_OPSTART,
        S_OPWAIT,
        S_PROBE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] hash_value;
        logic [31:0]        item_key;
        logic [31:0]        item_payload;
        logic [9:0]         position_index;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] found_key;
        logic [31:0] found_payload;
        logic [10:0] entry_count;
    } t_out_item;

    typedef struct packed {
        logic              used;
        logic [WORD_W-1:0] hash;
        logic [WORD_W-1:0] key;
        logic [WORD_W-1:0] payload;
    } t_slot;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] dividend;
        logic [SIZE_W-1:0] divisor;
    } t_mod_req;

endpackage
`default_nettype wire

[rtl/lph_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module lph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

[rtl/lph_mod.sv]
// Bit-serial remainder unit: |hash| mod table size, one dividend bit per cycle.
// Depends on lph_pkg.
`default_nettype none
module lph_mod (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire lph_pkg::t_mod_req        i_req,
    output logic                          o_done,
    output logic [lph_pkg::ADDR_W-1:0]    o_rem
);
    import lph_pkg::*;

    localparam int CNT_W = $clog2(WORD_W + 1);

    logic [WORD_W-1:0] r_dvd;
    logic [SIZE_W-1:0] r_div;
    logic [SIZE_W:0]   r_rem;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic [WORD_W-1:0] mag;
    logic [SIZE_W:0]   trial;

    assign mag   = i_req.dividend[WORD_W-1] ? (WORD_W'(0) - i_req.dividend) : i_req.dividend;
    assign trial = {r_rem[SIZE_W-1:0], r_dvd[WORD_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(WORD_W);
            r_dvd  <= mag;
            r_div  <= i_req.divisor;
            r_rem  <= '0;
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
                r_dvd <= {r_dvd[WORD_W-2:0], 1'b0};
                r_rem <= (trial >= {1'b0, r_div}) ? (trial - {1'b0, r_div}) : trial;
            end
        end
    end

    assign o_done = r_busy && (r_cnt == '0);
    assign o_rem  = r_rem[ADDR_W-1:0];

endmodule
`default_nettype wire

[rtl/linear_probe_hash_table.sv]
// Top level of the linear-probe hash table: control sequencer and two slot banks.
// Depends on lph_pkg, lph_ram and lph_mod.
//
// One item at a time. Retrieve and remove find the start slot with the bit-serial
// remainder unit and then probe slot by slot, up to the table size; insert stops at
// the first free slot; get scans from slot 0 with no remainder step. A resize runs
// first when needed: the spare bank is cleared, then each used old slot is rehashed
// and placed by probing, empty old slots are skipped, and after that the banks swap.
// After reset and after a write of initial_size a clearing pass runs during which no
// item is accepted. Configuration writes are taken only while idle. A finished result
// sits in an output register so the next item can be taken while it waits.
`default_nettype none
module linear_probe_hash_table (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire lph_pkg::t_in_item         i_in_item,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output lph_pkg::t_out_item             o_out_item,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic                      i_cfg_index,
    input  wire logic [lph_pkg::SIZE_W-1:0] i_cfg_data
);
    import lph_pkg::*;

    t_state            r_state, n_state;
    t_in_item          r_item;
    t_out_item         r_out;
    logic              r_out_vld;
    logic [SIZE_W-1:0] r_size, r_tgt_size, r_psize, r_icnt, r_ridx, r_pos, r_occ;
    logic [PCT_W-1:0]  r_fill;
    logic [ADDR_W-1:0] r_cidx, r_dpos, r_gcnt;
    logic              r_cbank, r_crs, r_bank, r_pb, r_dv;
    t_mode             r_mode;
    t_status           r_status;
    logic [WORD_W-1:0] r_fk, r_fp;
    t_slot             r_ent;
    logic [PROD_W-1:0] r_pgrow, r_pshr, r_xins, r_xrem;

    t_slot             rd0, rd1, rd_pb, rd_act, wr_data;
    logic              we0, we1, wr_bank, wr_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    t_mod_req          mreq;
    logic              m_done;
    logic [ADDR_W-1:0] m_rem;

    logic              in_acc, cfg_acc, cfg_size;
    logic [SIZE_W:0]   dbl;
    logic [SIZE_W-1:0] grow_size, pos_nxt, init_size;
    logic              dec_fin, dec_rs;
    t_status           dec_status;
    logic [SIZE_W-1:0] dec_size;
    t_state            dec_next;
    logic              hit, hit_v, miss_end, issue;
    t_mode             op_mode;

    assign in_acc     = i_in_valid && o_in_ready;
    assign cfg_acc    = i_cfg_valid && o_cfg_ready;
    assign cfg_size   = cfg_acc && (i_cfg_index == CFG_INIT_SIZE);
    assign o_in_ready = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    assign init_size = (i_cfg_data == '0) ? SIZE_W'(MIN_SLOTS) :
                       (i_cfg_data > SIZE_W'(MAX_SLOTS)) ? SIZE_W'(MAX_SLOTS) : i_cfg_data;

    assign rd_pb  = r_pb ? rd1 : rd0;
    assign rd_act = r_bank ? rd1 : rd0;

    always_comb begin
        unique case (t_action'(r_item.action))
            ACT_INSERT:   op_mode = M_INSERT;
            ACT_REMOVE:   op_mode = M_REMOVE;
            ACT_RETRIEVE: op_mode = M_RETRIEVE;
            default:      op_mode = M_GET;
        endcase
    end

    // Resize and early-exit decision
    assign dbl       = {r_size, 1'b0};
    assign grow_size = (dbl > (SIZE_W+1)'(MAX_SLOTS)) ? SIZE_W'(MAX_SLOTS) : dbl[SIZE_W-1:0];

    always_comb begin
        dec_fin    = 1'b0;
        dec_rs     = 1'b0;
        dec_status = ST_OK;
        dec_size   = r_size;
        unique case (t_action'(r_item.action))
            ACT_INSERT: begin
                if (r_occ >= r_size) begin
                    dec_fin    = 1'b1;
                    dec_status = ST_FULL;
                end else if (r_xins >= r_pgrow) begin
                    if (grow_size == r_size) begin
                        dec_status = ST_SAT;
                    end else begin
                        dec_rs   = 1'b1;
                        dec_size = grow_size;
                    end
                end
            end
            ACT_REMOVE: begin
                if (r_occ == '0) begin
                    dec_fin    = 1'b1;
                    dec_status = ST_FULL;
                end else if ((r_xrem < r_pshr) && (r_size > SIZE_W'(MIN_SLOTS)) &&
                             (r_occ <= (r_size >> 1))) begin
                    dec_rs   = 1'b1;
                    dec_size = r_size >> 1;
                end
            end
            ACT_RETRIEVE: begin
                if (r_occ == '0) begin
                    dec_fin    = 1'b1;
                    dec_status = ST_FULL;
                end
            end
            default: begin
                if (r_occ == '0) begin
                    dec_fin    = 1'b1;
                    dec_status = ST_FULL;
                end else if ({1'b0, r_item.position_index} >= r_occ) begin
                    dec_fin    = 1'b1;
                    dec_status = ST_NOTFOUND;
                end
            end
        endcase
        if (dec_fin) begin
            dec_next = S_DONE;
        end else if (dec_rs) begin
            dec_next = S_CLEAR;
        end else if (t_action'(r_item.action) == ACT_GET) begin
            dec_next = S_PROBE;
        end else begin
            dec_next = S_OPSTART;
        end
    end

    // Probe pipeline: one read issued per cycle, data checked in the cycle after
    always_comb begin
        case (r_mode) inside
            M_INSERT, M_PLACE: hit = !rd_pb.used;
            M_REMOVE:   hit = rd_pb.used && (rd_pb.key == r_item.item_key) &&
                              (rd_pb.payload == r_item.item_payload);
            M_RETRIEVE: hit = rd_pb.used && (rd_pb.key == r_item.item_key);
            default:    hit = rd_pb.used && (r_gcnt == r_item.position_index);
        endcase
    end

    assign hit_v    = (r_state == S_PROBE) && r_dv && hit;
    assign miss_end = (r_state == S_PROBE) && !r_dv && (r_icnt >= r_psize);
    assign issue    = (r_state == S_PROBE) && !hit_v && (r_icnt < r_psize);
    assign pos_nxt  = ((r_pos + 1'b1) >= r_psize) ? '0 : (r_pos + 1'b1);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:   if (r_cidx == '1) n_state = r_crs ? S_RS_RD : S_IDLE;
            S_IDLE:    if (in_acc) n_state = S_CALC;
            S_CALC:    n_state = S_DECIDE;
            S_DECIDE:  n_state = dec_next;
            S_RS_RD:   n_state = (r_ridx >= r_size) ? S_OPSTART : S_RS_CHK;
            S_RS_CHK:  n_state = rd_act.used ? S_RS_WAIT : S_RS_RD;
            S_RS_WAIT: if (m_done) n_state = S_PROBE;
            S_OPSTART: n_state = S_OPWAIT;
            S_OPWAIT:  if (m_done) n_state = S_PROBE;
            S_PROBE: begin
                if (hit_v || miss_end) n_state = (r_mode == M_PLACE) ? S_RS_RD : S_DONE;
            end
            S_DONE:    if (!r_out_vld || i_out_ready) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
        if (cfg_size) n_state = S_CLEAR;
    end

    // Memory and remainder unit controls
    always_comb begin
        wr_en   = 1'b0;
        wr_bank = r_pb;
        wr_addr = r_dpos;
        wr_data = '0;
        rd_addr = r_pos[ADDR_W-1:0];
        mreq    = '0;
        unique case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_bank = r_cbank;
                wr_addr = r_cidx;
            end
            S_RS_RD: rd_addr = r_ridx[ADDR_W-1:0];
            S_RS_CHK: begin
                mreq.start    = rd_act.used;
                mreq.dividend = rd_act.hash;
                mreq.divisor  = r_tgt_size;
            end
            S_OPSTART: begin
                mreq.start    = 1'b1;
                mreq.dividend = r_item.hash_value;
                mreq.divisor  = r_size;
            end
            S_PROBE: begin
                if (hit_v) begin
                    case (r_mode)
                        M_INSERT: begin
                            wr_en   = 1'b1;
                            wr_data = {1'b1, r_item.hash_value, r_item.item_key,
                                       r_item.item_payload};
                        end
                        M_PLACE: begin
                            wr_en   = 1'b1;
                            wr_data = {1'b1, r_ent.hash, r_ent.key, r_ent.payload};
                        end
                        M_REMOVE: begin
                            wr_en   = 1'b1;
                            wr_data = {1'b0, rd_pb.hash, rd_pb.key, rd_pb.payload};
                        end
                        default: wr_en = 1'b0;
                    endcase
                end
            end
            default: wr_en = 1'b0;
        endcase
    end

    assign we0 = wr_en && !wr_bank;
    assign we1 = wr_en && wr_bank;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_cidx    <= '0;
            r_cbank   <= 1'b0;
            r_crs     <= 1'b0;
            r_bank    <= 1'b0;
            r_size    <= SIZE_W'(MIN_SLOTS);
            r_occ     <= '0;
            r_fill    <= PCT_W'(RESET_FILL);
            r_out_vld <= 1'b0;
            r_dv      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_out_vld && i_out_ready && (r_state != S_DONE)) r_out_vld <= 1'b0;
            unique case (r_state)
                S_CLEAR: r_cidx <= r_cidx + 1'b1;
                S_IDLE: begin
                    if (in_acc) begin
                        r_item   <= i_in_item;
                        r_status <= ST_OK;
                        r_fk     <= '0;
                        r_fp     <= '0;
                    end
                end
                S_CALC: begin
                    r_pgrow <= (PROD_W'(r_fill) + PROD_W'(1)) * PROD_W'(r_size);
                    r_pshr  <= PROD_W'(r_fill[PCT_W-1:2]) * PROD_W'(r_size);
                    r_xins  <= (PROD_W'(r_occ) + PROD_W'(1)) * PROD_W'(PCT_SCALE);
                    r_xrem  <= (PROD_W'(r_occ) - PROD_W'(1)) * PROD_W'(PCT_SCALE);
                end
                S_DECIDE: begin
                    r_status <= dec_status;
                    if (dec_rs) begin
                        r_tgt_size <= dec_size;
                        r_cidx     <= '0;
                        r_cbank    <= !r_bank;
                        r_crs      <= 1'b1;
                        r_ridx     <= '0;
                    end
                    r_pos  <= '0;
                    r_icnt <= '0;
                    r_gcnt <= '0;
                    r_dv   <= 1'b0;
                    r_pb   <= r_bank;
                    r_psize <= r_size;
                    r_mode <= op_mode;
                end
                S_RS_RD: begin
                    if (r_ridx >= r_size) begin
                        r_bank <= !r_bank;
                        r_size <= r_tgt_size;
                        r_crs  <= 1'b0;
                    end
                end
                S_RS_CHK: begin
                    if (rd_act.used) begin
                        r_ent <= rd_act;
                    end else begin
                        r_ridx <= r_ridx + 1'b1;
                    end
                end
                S_RS_WAIT: begin
                    if (m_done) begin
                        r_pos   <= {1'b0, m_rem};
                        r_icnt  <= '0;
                        r_dv    <= 1'b0;
                        r_pb    <= !r_bank;
                        r_psize <= r_tgt_size;
                        r_mode  <= M_PLACE;
                    end
                end
                S_OPWAIT: begin
                    if (m_done) begin
                        r_pos   <= {1'b0, m_rem};
                        r_icnt  <= '0;
                        r_gcnt  <= '0;
                        r_dv    <= 1'b0;
                        r_pb    <= r_bank;
                        r_psize <= r_size;
                        r_mode  <= op_mode;
                    end
                end
                S_PROBE: begin
                    if (issue) begin
                        r_pos  <= pos_nxt;
                        r_icnt <= r_icnt + 1'b1;
                        r_dpos <= r_pos[ADDR_W-1:0];
                        r_dv   <= 1'b1;
                    end else begin
                        r_dv <= 1'b0;
                    end
                    if (r_dv && rd_pb.used && !hit && (r_mode == M_GET)) begin
                        r_gcnt <= r_gcnt + 1'b1;
                    end
                    if (hit_v) begin
                        case (r_mode)
                            M_INSERT: r_occ <= r_occ + 1'b1;
                            M_REMOVE: r_occ <= r_occ - 1'b1;
                            M_PLACE:  r_ridx <= r_ridx + 1'b1;
                            default: begin
                                r_fk <= rd_pb.key;
                                r_fp <= rd_pb.payload;
                            end
                        endcase
                    end else if (miss_end) begin
                        if (r_mode == M_PLACE) begin
                            r_ridx <= r_ridx + 1'b1;
                        end else if (r_mode != M_INSERT) begin
                            r_status <= ST_NOTFOUND;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_out_vld || i_out_ready) begin
                        r_out_vld           <= 1'b1;
                        r_out.status        <= r_status;
                        r_out.found_key     <= r_fk;
                        r_out.found_payload <= r_fp;
                        r_out.entry_count   <= r_occ;
                    end
                end
                default: r_dv <= 1'b0;
            endcase
            if (cfg_acc) begin
                if (i_cfg_index == CFG_INIT_SIZE) begin
                    r_size  <= init_size;
                    r_occ   <= '0;
                    r_cidx  <= '0;
                    r_cbank <= r_bank;
                    r_crs   <= 1'b0;
                end else begin
                    r_fill <= i_cfg_data[PCT_W-1:0];
                end
            end
        end
    end

    lph_ram #(.WIDTH($bits(t_slot)), .DEPTH(MAX_SLOTS)) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (we0),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rd0)
    );

    lph_ram #(.WIDTH($bits(t_slot)), .DEPTH(MAX_SLOTS)) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (we1),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rd1)
    );

    lph_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mreq),
        .o_done  (m_done),
        .o_rem   (m_rem)
    );

`ifndef SYNTHESIS
    a_occ_le_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_occ <= r_size))
        else $error("occupancy above table size");

    a_size_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_size != '0) && (r_size <= SIZE_W'(MAX_SLOTS)))
        else $error("table size out of range");

    a_probe_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> (r_pos < r_psize))
        else $error("probe position beyond table");

    a_mod_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_done |-> ((r_state == S_OPWAIT) || (r_state == S_RS_WAIT)))
        else $error("remainder finished outside a wait state");
`endif

endmodule
`default_nettype wire

[verif/tb.sv]
// Testbench for linear_probe_hash_table: directed table and cases, then random phases checked
// against an in-bench model of the slot array. Depends on rtl/lph_pkg.sv and the RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import lph_pkg::*;

    localparam int IDLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        t_in_item  item;
        bit        fixed;
        t_out_item res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    t_in_item    in_item = '0;
    logic        out_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_index = 1'b0;
    logic [10:0] cfg_data = '0;
    logic        o_in_ready, o_out_valid, o_cfg_ready;
    t_out_item   o_out_item;

    linear_probe_hash_table i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_item (o_out_item),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // table model
    bit          tbl_used [MAX_SLOTS];
    logic [31:0] tbl_hash [MAX_SLOTS];
    logic [31:0] tbl_key  [MAX_SLOTS];
    logic [31:0] tbl_pay  [MAX_SLOTS];
    int unsigned tbl_size, tbl_count, init_size, fill_pct;

    t_out_item   lookup_q[$];
    int          fails = 0;
    int          burst_left = 0;
    bit          hold_req = 0;

    function automatic int unsigned home_slot(logic [31:0] h);
        logic [31:0] mag;
        mag = h[31] ? (32'd0 - h) : h;
        return mag % tbl_size;
    endfunction

    function automatic void place(logic [31:0] h, logic [31:0] k, logic [31:0] p);
        int unsigned pos;
        pos = home_slot(h);
        for (int i = 0; i < tbl_size; i++) begin
            if (!tbl_used[pos]) begin
                tbl_used[pos] = 1;
                tbl_hash[pos] = h;
                tbl_key[pos] = k;
                tbl_pay[pos] = p;
                tbl_count++;
                return;
            end
            pos = (pos + 1 >= tbl_size) ? 0 : pos + 1;
        end
    endfunction

    function automatic void rehash(int unsigned tgt_size);
        bit          o_used [MAX_SLOTS];
        logic [31:0] o_hash [MAX_SLOTS];
        logic [31:0] o_key  [MAX_SLOTS];
        logic [31:0] o_pay  [MAX_SLOTS];
        int unsigned old;
        old = tbl_size;
        o_used = tbl_used;
        o_hash = tbl_hash;
        o_key = tbl_key;
        o_pay = tbl_pay;
        foreach (tbl_used[i]) tbl_used[i] = 0;
        tbl_size = tgt_size;
        tbl_count = 0;
        for (int i = 0; i < old; i++)
            if (o_used[i]) place(o_hash[i], o_key[i], o_pay[i]);
    endfunction

    function automatic void clear_table();
        foreach (tbl_used[i]) tbl_used[i] = 0;
        tbl_count = 0;
        if (init_size == 0) tbl_size = MIN_SLOTS;
        else if (init_size > MAX_SLOTS) tbl_size = MAX_SLOTS;
        else tbl_size = init_size;
    endfunction

    function automatic t_out_item hash_table_step(t_in_item it);
        t_out_item   r;
        int unsigned pos, ns, seen;
        r = '0;
        case (t_action'(it.action))
            ACT_INSERT: begin
                if (tbl_count >= tbl_size) begin
                    r.status = ST_FULL;
                end else begin
                    if ((tbl_count + 1) * 100 / tbl_size > fill_pct) begin
                        ns = (tbl_size * 2 > MAX_SLOTS) ? MAX_SLOTS : tbl_size * 2;
                        if (ns == tbl_size) r.status = ST_SAT;
                        else rehash(ns);
                    end
                    place(it.hash_value, it.item_key, it.item_payload);
                end
            end
            ACT_REMOVE: begin
                if (tbl_count == 0) begin
                    r.status = ST_FULL;
                end else begin
                    if ((tbl_count - 1) * 100 / tbl_size < fill_pct / 4 &&
                        tbl_size > MIN_SLOTS && tbl_count <= tbl_size / 2)
                        rehash(tbl_size / 2);
                    r.status = ST_NOTFOUND;
                    pos = home_slot(it.hash_value);
                    for (int i = 0; i < tbl_size; i++) begin
                        if (tbl_used[pos] && tbl_key[pos] == it.item_key &&
                            tbl_pay[pos] == it.item_payload) begin
                            tbl_used[pos] = 0;
                            tbl_count--;
                            r.status = ST_OK;
                            break;
                        end
                        pos = (pos + 1 >= tbl_size) ? 0 : pos + 1;
                    end
                end
            end
            ACT_RETRIEVE: begin
                if (tbl_count == 0) begin
                    r.status = ST_FULL;
                end else begin
                    r.status = ST_NOTFOUND;
                    pos = home_slot(it.hash_value);
                    for (int i = 0; i < tbl_size; i++) begin
                        if (tbl_used[pos] && tbl_key[pos] == it.item_key) begin
                            r.status = ST_OK;
                            r.found_key = tbl_key[pos];
                            r.found_payload = tbl_pay[pos];
                            break;
                        end
                        pos = (pos + 1 >= tbl_size) ? 0 : pos + 1;
                    end
                end
            end
            default: begin
                if (tbl_count == 0) begin
                    r.status = ST_FULL;
                end else if (it.position_index >= tbl_count) begin
                    r.status = ST_NOTFOUND;
                end else begin
                    seen = 0;
                    r.status = ST_NOTFOUND;
                    for (int i = 0; i < tbl_size; i++) begin
                        if (tbl_used[i]) begin
                            if (seen == it.position_index) begin
                                r.status = ST_OK;
                                r.found_key = tbl_key[i];
                                r.found_payload = tbl_pay[i];
                                break;
                            end
                            seen++;
                        end
                    end
                end
            end
        endcase
        r.entry_count = tbl_count[10:0];
        return r;
    endfunction

    function automatic t_in_item mk(t_action a, logic [31:0] h, logic [31:0] k,
                                    logic [31:0] p, logic [9:0] n);
        t_in_item it;
        it.action = a;
        it.hash_value = h;
        it.item_key = k;
        it.item_payload = p;
        it.position_index = n;
        return it;
    endfunction

    function automatic t_out_item mkr(t_status s, logic [31:0] k, logic [31:0] p,
                                      logic [10:0] c);
        t_out_item r;
        r.status = s;
        r.found_key = k;
        r.found_payload = p;
        r.entry_count = c;
        return r;
    endfunction

    task automatic report(string what, logic [31:0] want, logic [31:0] got);
        $display("%0t mismatch %s: expected %0h got %0h", $realtime, what, want, got);
        fails++;
    endtask

    task automatic send(t_in_item it, bit fixed = 0, t_out_item want = '0);
        t_out_item pred;
        int        gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_item <= it;
        in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        pred = hash_table_step(it);
        lookup_q.push_back(fixed ? want : pred);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (lookup_q.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_index idx, logic [10:0] d);
        drain();
        repeat (40) @(posedge i_clk);
        cfg_index <= idx;
        cfg_data <= d;
        cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_INIT_SIZE) begin
            init_size = d;
            clear_table();
        end else begin
            fill_pct = d[6:0];
        end
    endtask

    function automatic logic [31:0] rand_hash();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 100);
            2: return 32'd0 - $urandom_range(1, 100);
            default: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
        endcase
    endfunction

    function automatic t_in_item rand_item();
        t_in_item    it;
        int unsigned sel, r;
        it = mk(ACT_INSERT, rand_hash(), $urandom_range(0, 1) ? $urandom_range(0, 20)
                : $urandom, $urandom, 10'($urandom_range(0, tbl_count + 2)));
        sel = $urandom_range(0, 99);
        if (sel < 40) return it;
        if (sel < 85) begin
            it.action = (sel < 65) ? ACT_REMOVE : ACT_RETRIEVE;
            if (tbl_count > 0 && $urandom_range(0, 3) != 0) begin
                r = $urandom_range(0, tbl_count - 1);
                for (int i = 0; i < tbl_size; i++) begin
                    if (tbl_used[i]) begin
                        if (r == 0) begin
                            it.hash_value = tbl_hash[i];
                            it.item_key = tbl_key[i];
                            it.item_payload = tbl_pay[i];
                            break;
                        end
                        r--;
                    end
                end
            end
            return it;
        end
        it.action = ACT_GET;
        if ($urandom_range(0, 4) == 0) it.position_index = 10'($urandom);
        return it;
    endfunction

    initial begin
        t_row rows[16];
        rows[0]  = '{mk(ACT_GET, 0, 0, 0, 0), 1, mkr(ST_FULL, 0, 0, 0)};
        rows[1]  = '{mk(ACT_RETRIEVE, 0, 0, 0, 0), 1, mkr(ST_FULL, 0, 0, 0)};
        rows[2]  = '{mk(ACT_REMOVE, 0, 0, 0, 0), 1, mkr(ST_FULL, 0, 0, 0)};
        rows[3]  = '{mk(ACT_INSERT, 32'h8000_0000, 0, 0, 0), 1, mkr(ST_OK, 0, 0, 1)};
        rows[4]  = '{mk(ACT_INSERT, 32'h7fff_ffff, '1, '1, '1), 1, mkr(ST_OK, 0, 0, 2)};
        rows[5]  = '{mk(ACT_INSERT, '1, 5, 7, 0), 1, mkr(ST_OK, 0, 0, 3)};
        rows[6]  = '{mk(ACT_INSERT, 31, 5, 8, 0), 1, mkr(ST_OK, 0, 0, 4)};
        rows[7]  = '{mk(ACT_RETRIEVE, 31, 5, 0, 0), 0, '0};
        rows[8]  = '{mk(ACT_RETRIEVE, 0, '1, 0, 0), 0, '0};
        rows[9]  = '{mk(ACT_RETRIEVE, 3, 123, 0, 0), 1, mkr(ST_NOTFOUND, 0, 0, 4)};
        rows[10] = '{mk(ACT_GET, 0, 0, 0, 0), 0, '0};
        rows[11] = '{mk(ACT_GET, 0, 0, 0, 3), 0, '0};
        rows[12] = '{mk(ACT_GET, 0, 0, 0, '1), 1, mkr(ST_NOTFOUND, 0, 0, 4)};
        rows[13] = '{mk(ACT_REMOVE, '1, 5, 9, 0), 1, mkr(ST_NOTFOUND, 0, 0, 4)};
        rows[14] = '{mk(ACT_REMOVE, '1, 5, 7, 0), 1, mkr(ST_OK, 0, 0, 3)};
        rows[15] = '{mk(ACT_REMOVE, 32'h8000_0000, 0, 0, 0), 1, mkr(ST_OK, 0, 0, 2)};

        init_size = 32;
        fill_pct = RESET_FILL;
        clear_table();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i]) send(rows[i].item, rows[i].fixed, rows[i].res);

        // one-slot table: second insert is refused
        cfg_write(CFG_FILL_PCT, 100);
        cfg_write(CFG_INIT_SIZE, 1);
        send(mk(ACT_INSERT, 9, 1, 2, 0));
        send(mk(ACT_INSERT, 9, 3, 4, 0), 1, mkr(ST_FULL, 0, 0, 1));

        // largest size, saturated growth
        cfg_write(CFG_FILL_PCT, 0);
        cfg_write(CFG_INIT_SIZE, 11'h7ff);
        for (int i = 0; i < 14; i++) send(mk(ACT_INSERT, rand_hash(), i, $urandom, 0));

        // size 600 with a zero fill limit: these inserts stay below the growth threshold
        cfg_write(CFG_INIT_SIZE, 600);
        for (int i = 0; i < 3; i++) send(mk(ACT_INSERT, rand_hash(), i, i, 0));

        for (int ph = 0; ph < 8; ph++) begin
            cfg_write(CFG_FILL_PCT, 11'((ph == 0) ? 127 : (ph == 1) ? 0 :
                      $urandom_range(0, 3) == 0 ? $urandom_range(0, 127)
                      : $urandom_range(40, 100)));
            cfg_write(CFG_INIT_SIZE, 11'((ph == 0) ? 0 : (ph == 1) ? 48 :
                      $urandom_range(0, 4) == 0 ? $urandom_range(65, 200)
                      : $urandom_range(1, 64)));
            for (int n = 0; n < 70; n++) begin
                if (ph == 2 && n == 10) hold_req = 1;
                if (ph == 4 && n == 35) drain();
                send(rand_item());
            end
        end

        drain();
        repeat (100) @(posedge i_clk);
        if (fails == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

    initial begin
        int mode_cycles, mode, tick;
        mode_cycles = 0;
        mode = 0;
        tick = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 0;
            end else begin
                if (mode_cycles == 0) begin
                    mode = $urandom_range(0, 2);
                    mode_cycles = $urandom_range(16, 128);
                end
                mode_cycles--;
                tick++;
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    default: out_ready <= (tick % 4 != 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (o_out_valid && out_ready) begin
            if (lookup_q.size() == 0) begin
                report("unexpected result", 0, o_out_item.entry_count);
            end else begin
                want = lookup_q.pop_front();
                if (o_out_item.status !== want.status)
                    report("status", want.status, o_out_item.status);
                if (o_out_item.found_key !== want.found_key)
                    report("found_key", want.found_key, o_out_item.found_key);
                if (o_out_item.found_payload !== want.found_payload)
                    report("found_payload", want.found_payload, o_out_item.found_payload);
                if (o_out_item.entry_count !== want.entry_count)
                    report("entry_count", want.entry_count, o_out_item.entry_count);
            end
        end
    end

    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready) ||
            (cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
`default_nettype wire
